/* sv/gate_motion_controller_core_macros.svh */
// Assertion helpers for the gate motion controller.
`ifndef GATE_MOTION_CONTROLLER_CORE_MACROS_SVH
`define GATE_MOTION_CONTROLLER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define GMC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gmc assertion failed");
// next-cycle implication
`define GMC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gmc assertion failed");
`else
`define GMC_ASSERT_IMP(lbl, ante, cons)
`define GMC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* sv/gmc_pkg.sv */
`default_nettype none

package gmc_pkg;

	localparam int unsigned NBTN = 4;
	localparam int unsigned BTN_DO = 0;
	localparam int unsigned BTN_DC = 1;
	localparam int unsigned BTN_SO = 2;
	localparam int unsigned BTN_SC = 3;

	localparam int unsigned REG_W = 8;
	localparam int unsigned CNT_W = 8;
	localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REVERSE = 2'd2;

	localparam logic [REG_W-1:0] HOLD_RST    = 8'd25;
	localparam logic [REG_W-1:0] SETTLE_RST  = 8'd3;
	localparam logic [REG_W-1:0] REVERSE_RST = 8'd25;

	localparam int unsigned GATE_W = 3;
	localparam logic [GATE_W-1:0] GC_IDLE_CLOSED = 3'd0;
	localparam logic [GATE_W-1:0] GC_IDLE_OPEN   = 3'd1;
	localparam logic [GATE_W-1:0] GC_OPENING     = 3'd2;
	localparam logic [GATE_W-1:0] GC_CLOSING     = 3'd3;
	localparam logic [GATE_W-1:0] GC_STOPPED     = 3'd4;
	localparam logic [GATE_W-1:0] GC_REVERSING   = 3'd5;

	typedef enum logic [2:0] {
		EV_NONE       = 3'd0,
		EV_OPEN_AUTO  = 3'd1,
		EV_CLOSE_AUTO = 3'd2,
		EV_OPEN_MAN   = 3'd3,
		EV_CLOSE_MAN  = 3'd4,
		EV_RELEASE    = 3'd5,
		EV_STOP       = 3'd6
	} event_t;

	typedef enum logic [5:0] {
		GS_IDLE_CLOSED = 6'b000001,
		GS_IDLE_OPEN   = 6'b000010,
		GS_OPENING     = 6'b000100,
		GS_CLOSING     = 6'b001000,
		GS_STOPPED     = 6'b010000,
		GS_REVERSING   = 6'b100000
	} gate_state_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'b001,
		PH_SETTLE  = 3'b010,
		PH_REVERSE = 3'b100
	} phase_t;

	typedef struct packed {
		event_t ev;
		logic   sec;
	} evt_t;

	typedef struct packed {
		gate_state_t gate;
		logic        safety_busy;
		gate_state_t gate_nxt;
	} fsm_stat_t;

	typedef struct packed {
		logic motor_open;
		logic motor_close;
		logic led_red;
		logic led_green;
		logic led_blue;
	} drive_t;

	function automatic logic [GATE_W-1:0] gate_code(gate_state_t s);
		logic [GATE_W-1:0] c;
		unique case (s)
			GS_IDLE_CLOSED: c = GC_IDLE_CLOSED;
			GS_IDLE_OPEN:   c = GC_IDLE_OPEN;
			GS_OPENING:     c = GC_OPENING;
			GS_CLOSING:     c = GC_CLOSING;
			GS_STOPPED:     c = GC_STOPPED;
			GS_REVERSING:   c = GC_REVERSING;
			default:        c = GC_IDLE_CLOSED;
		endcase
		return c;
	endfunction

	function automatic drive_t gate_drive(gate_state_t s);
		drive_t d;
		d.motor_open  = (s == GS_OPENING) || (s == GS_REVERSING);
		d.motor_close = (s == GS_CLOSING);
		d.led_red     = (s == GS_CLOSING) || (s == GS_STOPPED) || (s == GS_REVERSING);
		d.led_green   = (s == GS_IDLE_OPEN) || (s == GS_OPENING) || (s == GS_STOPPED);
		d.led_blue    = (s == GS_IDLE_CLOSED) || (s == GS_IDLE_OPEN) || (s == GS_REVERSING);
		return d;
	endfunction

endpackage

`default_nettype wire

/* sv/gmc_buttons.sv */
`default_nettype none

module gmc_buttons (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire logic [gmc_pkg::NBTN-1:0]       btn_now,
	input  wire logic [gmc_pkg::REG_W-1:0]      hold_ticks,
	output gmc_pkg::evt_t                       evt
);

	logic [gmc_pkg::NBTN-1:0]      last_q, manual_q;
	logic [gmc_pkg::CNT_W-1:0]     hold_q [gmc_pkg::NBTN];
	logic                          sec_was_q, drv_sup_q;

	logic [gmc_pkg::CNT_W-1:0]     hold_n [gmc_pkg::NBTN];
	logic [gmc_pkg::NBTN-1:0]      man_mid, man_n, released;
	logic                          sec_act, sec_just, sup_mid, sup_n;
	gmc_pkg::event_t               ev;
	logic                          sec;

	always_comb begin
		for (int i = 0; i < gmc_pkg::NBTN; i++) begin
			hold_n[i]  = hold_q[i];
			man_mid[i] = manual_q[i];
			if (btn_now[i] && !last_q[i]) begin
				hold_n[i]  = '0;
				man_mid[i] = 1'b0;
			end else if (btn_now[i] && hold_q[i] != gmc_pkg::CNT_MAX) begin
				hold_n[i] = hold_q[i] + 1'b1;
			end
			if (btn_now[i] && hold_n[i] >= hold_ticks)
				man_mid[i] = 1'b1;
			released[i] = !btn_now[i] && last_q[i];
		end
	end

	assign sec_act  = btn_now[gmc_pkg::BTN_SO] || btn_now[gmc_pkg::BTN_SC];
	assign sec_just = sec_act && !sec_was_q;
	assign sup_mid  = drv_sup_q || sec_act;
	assign sup_n    = (!sec_act && !btn_now[gmc_pkg::BTN_DO] && !btn_now[gmc_pkg::BTN_DC])
		? 1'b0 : sup_mid;

	// one event per tick; security first, releases before levels
	always_comb begin
		ev    = gmc_pkg::EV_NONE;
		sec   = 1'b0;
		man_n = man_mid;
		priority if (sec_just) begin
			ev  = gmc_pkg::EV_STOP;
			sec = 1'b1;
		end else if (released[gmc_pkg::BTN_SO]) begin
			ev  = man_mid[gmc_pkg::BTN_SO] ? gmc_pkg::EV_RELEASE : gmc_pkg::EV_OPEN_AUTO;
			sec = 1'b1;
			man_n[gmc_pkg::BTN_SO] = 1'b0;
		end else if (released[gmc_pkg::BTN_SC]) begin
			ev  = man_mid[gmc_pkg::BTN_SC] ? gmc_pkg::EV_RELEASE : gmc_pkg::EV_CLOSE_AUTO;
			sec = 1'b1;
			man_n[gmc_pkg::BTN_SC] = 1'b0;
		end else if (released[gmc_pkg::BTN_DO] && !sup_mid) begin
			ev = man_mid[gmc_pkg::BTN_DO] ? gmc_pkg::EV_RELEASE : gmc_pkg::EV_OPEN_AUTO;
			man_n[gmc_pkg::BTN_DO] = 1'b0;
		end else if (released[gmc_pkg::BTN_DC] && !sup_mid) begin
			ev = man_mid[gmc_pkg::BTN_DC] ? gmc_pkg::EV_RELEASE : gmc_pkg::EV_CLOSE_AUTO;
			man_n[gmc_pkg::BTN_DC] = 1'b0;
		end else if (sec_act) begin
			priority if (btn_now[gmc_pkg::BTN_SO] && btn_now[gmc_pkg::BTN_SC])
				ev = gmc_pkg::EV_STOP;
			else if (btn_now[gmc_pkg::BTN_SO] && man_mid[gmc_pkg::BTN_SO])
				ev = gmc_pkg::EV_OPEN_MAN;
			else if (btn_now[gmc_pkg::BTN_SC] && man_mid[gmc_pkg::BTN_SC])
				ev = gmc_pkg::EV_CLOSE_MAN;
			else
				ev = gmc_pkg::EV_NONE;
			sec = (ev != gmc_pkg::EV_NONE);
		end else if (!sup_mid) begin
			priority if (btn_now[gmc_pkg::BTN_DO] && btn_now[gmc_pkg::BTN_DC])
				ev = gmc_pkg::EV_STOP;
			else if (btn_now[gmc_pkg::BTN_DO] && man_mid[gmc_pkg::BTN_DO])
				ev = gmc_pkg::EV_OPEN_MAN;
			else if (btn_now[gmc_pkg::BTN_DC] && man_mid[gmc_pkg::BTN_DC])
				ev = gmc_pkg::EV_CLOSE_MAN;
			else
				ev = gmc_pkg::EV_NONE;
		end else begin
			ev = gmc_pkg::EV_NONE;
		end
	end

	assign evt.ev  = ev;
	assign evt.sec = sec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= '0;
			manual_q  <= '0;
			sec_was_q <= 1'b0;
			drv_sup_q <= 1'b0;
			for (int i = 0; i < gmc_pkg::NBTN; i++)
				hold_q[i] <= '0;
		end else if (en) begin
			last_q    <= btn_now;
			manual_q  <= man_n;
			sec_was_q <= sec_act;
			drv_sup_q <= sup_n;
			for (int i = 0; i < gmc_pkg::NBTN; i++)
				hold_q[i] <= hold_n[i];
		end
	end

endmodule

`default_nettype wire

/* sv/gmc_fsm.sv */
`default_nettype none

module gmc_fsm #(
	parameter int unsigned TIMER_BITS = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire gmc_pkg::evt_t              evt,
	input  wire logic                       limit_open_hit,
	input  wire logic                       limit_close_hit,
	input  wire logic                       obstacle_hit,
	input  wire logic [gmc_pkg::REG_W-1:0]  settle_ticks,
	input  wire logic [gmc_pkg::REG_W-1:0]  reverse_ticks,
	output gmc_pkg::fsm_stat_t              stat
);

	gmc_pkg::gate_state_t        gate_q, gate_n;
	gmc_pkg::phase_t             phase_q, phase_n;
	logic [TIMER_BITS-1:0]       tmr_q, tmr_n, tmr_dec;
	logic                        manual_q, manual_n;
	logic                        await_q, await_n;
	logic                        owns_q, owns_n;

	logic [TIMER_BITS+gmc_pkg::REG_W-1:0] settle_ext, reverse_ext;
	logic [TIMER_BITS-1:0]                settle_ld, reverse_ld;

	assign settle_ext  = {{TIMER_BITS{1'b0}}, settle_ticks};
	assign reverse_ext = {{TIMER_BITS{1'b0}}, reverse_ticks};
	assign settle_ld   = settle_ext[TIMER_BITS-1:0];
	assign reverse_ld  = reverse_ext[TIMER_BITS-1:0];
	assign tmr_dec     = (tmr_q != '0) ? tmr_q - 1'b1 : tmr_q;

	always_comb begin
		logic busy, started, go;
		gmc_pkg::gate_state_t cur;

		gate_n   = gate_q;
		phase_n  = phase_q;
		tmr_n    = tmr_q;
		manual_n = manual_q;
		await_n  = await_q;
		owns_n   = owns_q;
		busy     = (phase_q != gmc_pkg::PH_IDLE);
		started  = 1'b0;
		go       = 1'b0;

		// safety sequence
		unique case (phase_q)
			gmc_pkg::PH_SETTLE: begin
				tmr_n = tmr_dec;
				if (tmr_dec == '0) begin
					gate_n  = gmc_pkg::GS_REVERSING;
					phase_n = gmc_pkg::PH_REVERSE;
					tmr_n   = reverse_ld;
				end
			end
			gmc_pkg::PH_REVERSE: begin
				tmr_n = tmr_dec;
				if (tmr_dec == '0) begin
					gate_n  = gmc_pkg::GS_STOPPED;
					phase_n = gmc_pkg::PH_IDLE;
				end
			end
			default: phase_n = gmc_pkg::PH_IDLE;
		endcase

		if (limit_open_hit) begin
			if (gate_n == gmc_pkg::GS_OPENING)
				gate_n = gmc_pkg::GS_IDLE_OPEN;
			manual_n = 1'b0;
			owns_n   = 1'b0;
		end
		if (limit_close_hit) begin
			if (gate_n == gmc_pkg::GS_CLOSING)
				gate_n = gmc_pkg::GS_IDLE_CLOSED;
			manual_n = 1'b0;
			owns_n   = 1'b0;
		end

		if (obstacle_hit && gate_n == gmc_pkg::GS_CLOSING) begin
			gate_n   = gmc_pkg::GS_STOPPED;
			phase_n  = gmc_pkg::PH_SETTLE;
			tmr_n    = settle_ld;
			await_n  = 1'b1;
			manual_n = 1'b0;
			owns_n   = 1'b0;
			started  = 1'b1;
		end

		// button event; dropped while the safety sequence runs
		cur = gate_n;
		if (!busy && !started && evt.ev != gmc_pkg::EV_NONE && !(owns_n && !evt.sec)) begin
			go = 1'b1;
			if (await_n) begin
				if (evt.ev == gmc_pkg::EV_OPEN_AUTO || evt.ev == gmc_pkg::EV_CLOSE_AUTO) begin
					await_n  = 1'b0;
					manual_n = 1'b0;
				end else begin
					if (evt.ev == gmc_pkg::EV_RELEASE || evt.ev == gmc_pkg::EV_STOP)
						await_n = 1'b0;
					go = 1'b0;
				end
			end
		end

		if (go) begin
			unique case (evt.ev)
				gmc_pkg::EV_OPEN_AUTO: begin
					if (cur == gmc_pkg::GS_IDLE_CLOSED || cur == gmc_pkg::GS_STOPPED ||
					    cur == gmc_pkg::GS_CLOSING) begin
						gate_n   = gmc_pkg::GS_OPENING;
						manual_n = 1'b0;
						owns_n   = evt.sec;
					end
				end
				gmc_pkg::EV_CLOSE_AUTO: begin
					if (cur == gmc_pkg::GS_IDLE_OPEN || cur == gmc_pkg::GS_STOPPED ||
					    cur == gmc_pkg::GS_OPENING) begin
						gate_n   = gmc_pkg::GS_CLOSING;
						manual_n = 1'b0;
						owns_n   = evt.sec;
					end
				end
				gmc_pkg::EV_OPEN_MAN: begin
					if (cur != gmc_pkg::GS_IDLE_OPEN && cur != gmc_pkg::GS_REVERSING) begin
						gate_n   = gmc_pkg::GS_OPENING;
						manual_n = 1'b1;
						owns_n   = evt.sec;
					end
				end
				gmc_pkg::EV_CLOSE_MAN: begin
					if (cur != gmc_pkg::GS_IDLE_CLOSED && cur != gmc_pkg::GS_REVERSING) begin
						gate_n   = gmc_pkg::GS_CLOSING;
						manual_n = 1'b1;
						owns_n   = evt.sec;
					end
				end
				gmc_pkg::EV_RELEASE: begin
					if (manual_n && (cur == gmc_pkg::GS_OPENING || cur == gmc_pkg::GS_CLOSING)) begin
						gate_n   = gmc_pkg::GS_STOPPED;
						manual_n = 1'b0;
						owns_n   = 1'b0;
					end
				end
				gmc_pkg::EV_STOP: begin
					if (cur == gmc_pkg::GS_OPENING || cur == gmc_pkg::GS_CLOSING)
						gate_n = gmc_pkg::GS_STOPPED;
					manual_n = 1'b0;
					owns_n   = 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q   <= gmc_pkg::GS_IDLE_CLOSED;
			phase_q  <= gmc_pkg::PH_IDLE;
			tmr_q    <= '0;
			manual_q <= 1'b0;
			await_q  <= 1'b0;
			owns_q   <= 1'b0;
		end else if (en) begin
			gate_q   <= gate_n;
			phase_q  <= phase_n;
			tmr_q    <= tmr_n;
			manual_q <= manual_n;
			await_q  <= await_n;
			owns_q   <= owns_n;
		end
	end

	assign stat.gate        = gate_q;
	assign stat.safety_busy = (phase_q != gmc_pkg::PH_IDLE);
	assign stat.gate_nxt    = gate_n;

endmodule

`default_nettype wire

/* sv/gate_motion_controller_core.sv */
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   four button levels, limit and obstacle pulses
// out       output     out_valid / out_stall gate state, motor, LEDs, issued event
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One tick per cycle unless out_stall holds it: input register, one pass of logic, result register.
// An accepted tick is held in the input register, then its result in the result register.
// out_stall holds the result register and, through it, the input register.
// Reset is asynchronous, active low; the block takes a tick right after reset.
// cfg is always ready; each write to index 0 to 2 goes straight into its register, and index 3 is ignored.
`default_nettype none
`include "gate_motion_controller_core_macros.svh"

module gate_motion_controller_core #(
	parameter int unsigned TIMER_BITS = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,

	input  wire logic                              in_valid,
	output      logic                              in_stall,
	input  wire logic                              drv_open_btn,
	input  wire logic                              drv_close_btn,
	input  wire logic                              sec_open_btn,
	input  wire logic                              sec_close_btn,
	input  wire logic                              limit_open_hit,
	input  wire logic                              limit_close_hit,
	input  wire logic                              obstacle_hit,

	output      logic                              out_valid,
	input  wire logic                              out_stall,
	output      logic [gmc_pkg::GATE_W-1:0]        gate_state,
	output      logic                              motor_open,
	output      logic                              motor_close,
	output      logic                              led_red,
	output      logic                              led_green,
	output      logic                              led_blue,
	output      logic [2:0]                        issued_event,
	output      logic                              event_from_security,

	input  wire logic                              cfg_valid,
	output      logic                              cfg_ready,
	input  wire logic [gmc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [gmc_pkg::REG_W-1:0]         cfg_data
);

	logic [gmc_pkg::REG_W-1:0]  hold_ticks_q, settle_ticks_q, reverse_ticks_q;

	logic                       valid_s1;
	logic [gmc_pkg::NBTN-1:0]   btn_s1;
	logic                       lim_open_s1, lim_close_s1, obst_s1;
	logic                       advance, in_take;

	gmc_pkg::evt_t              evt;
	gmc_pkg::fsm_stat_t         stat;
	gmc_pkg::drive_t            drv;

	logic                       out_valid_q;
	logic [gmc_pkg::GATE_W-1:0] gate_q;
	gmc_pkg::drive_t            drv_q;
	gmc_pkg::event_t            ev_q;
	logic                       sec_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q    <= gmc_pkg::HOLD_RST;
			settle_ticks_q  <= gmc_pkg::SETTLE_RST;
			reverse_ticks_q <= gmc_pkg::REVERSE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				gmc_pkg::CFG_HOLD:    hold_ticks_q    <= cfg_data;
				gmc_pkg::CFG_SETTLE:  settle_ticks_q  <= cfg_data;
				gmc_pkg::CFG_REVERSE: reverse_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_take)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			btn_s1[gmc_pkg::BTN_DO] <= drv_open_btn;
			btn_s1[gmc_pkg::BTN_DC] <= drv_close_btn;
			btn_s1[gmc_pkg::BTN_SO] <= sec_open_btn;
			btn_s1[gmc_pkg::BTN_SC] <= sec_close_btn;
			lim_open_s1             <= limit_open_hit;
			lim_close_s1            <= limit_close_hit;
			obst_s1                 <= obstacle_hit;
		end
	end

	gmc_buttons u_buttons (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.btn_now    (btn_s1),
		.hold_ticks (hold_ticks_q),
		.evt        (evt)
	);

	gmc_fsm #(
		.TIMER_BITS (TIMER_BITS)
	) u_fsm (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (advance),
		.evt             (evt),
		.limit_open_hit  (lim_open_s1),
		.limit_close_hit (lim_close_s1),
		.obstacle_hit    (obst_s1),
		.settle_ticks    (settle_ticks_q),
		.reverse_ticks   (reverse_ticks_q),
		.stat            (stat)
	);

	assign drv = gmc_pkg::gate_drive(stat.gate_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			gate_q <= gmc_pkg::gate_code(stat.gate_nxt);
			drv_q  <= drv;
			ev_q   <= evt.ev;
			sec_q  <= evt.sec;
		end
	end

	assign out_valid           = out_valid_q;
	assign gate_state          = gate_q;
	assign motor_open          = drv_q.motor_open;
	assign motor_close         = drv_q.motor_close;
	assign led_red             = drv_q.led_red;
	assign led_green           = drv_q.led_green;
	assign led_blue            = drv_q.led_blue;
	assign issued_event        = ev_q;
	assign event_from_security = sec_q;

	`GMC_ASSERT_IMP(a_safety_state, stat.safety_busy, (stat.gate == gmc_pkg::GS_STOPPED) || (stat.gate == gmc_pkg::GS_REVERSING))
	`GMC_ASSERT_IMP(a_no_event_no_sec, out_valid_q && (ev_q == gmc_pkg::EV_NONE), !sec_q)
	`GMC_ASSERT_NXT(a_s1_held, valid_s1 && !advance, valid_s1)
	`GMC_ASSERT_NXT(a_result_lands, advance, out_valid_q)

endmodule

`default_nettype wire

/* tb/sv/tb_gate_motion_controller_core.sv */
`default_nettype none

module tb_gate_motion_controller_core;

	typedef struct packed {
		logic d_open;
		logic d_close;
		logic s_open;
		logic s_close;
		logic lim_open;
		logic lim_close;
		logic obstacle;
	} tick_t;

	typedef struct packed {
		logic [gmc_pkg::GATE_W-1:0] gate;
		logic                       motor_open;
		logic                       motor_close;
		logic                       led_red;
		logic                       led_green;
		logic                       led_blue;
		gmc_pkg::event_t            ev;
		logic                       from_sec;
	} gate_result_t;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

	localparam logic [gmc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	tick_t tick_drv = '0;

	logic out_valid;
	logic out_stall = 1'b0;
	logic [gmc_pkg::GATE_W-1:0] gate_state;
	logic motor_open, motor_close, led_red, led_green, led_blue;
	logic [2:0] issued_event;
	logic event_from_security;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [gmc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [gmc_pkg::REG_W-1:0] cfg_data = '0;

	gate_motion_controller_core i_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.drv_open_btn        (tick_drv.d_open),
		.drv_close_btn       (tick_drv.d_close),
		.sec_open_btn        (tick_drv.s_open),
		.sec_close_btn       (tick_drv.s_close),
		.limit_open_hit      (tick_drv.lim_open),
		.limit_close_hit     (tick_drv.lim_close),
		.obstacle_hit        (tick_drv.obstacle),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.gate_state          (gate_state),
		.motor_open          (motor_open),
		.motor_close         (motor_close),
		.led_red             (led_red),
		.led_green           (led_green),
		.led_blue            (led_blue),
		.issued_event        (issued_event),
		.event_from_security (event_from_security),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data)
	);

	// gate controller state as the testbench sees it
	logic [gmc_pkg::REG_W-1:0] cfg_hold, cfg_settle, cfg_reverse;
	logic [gmc_pkg::GATE_W-1:0] gate_st;
	logic btn_last [gmc_pkg::NBTN];
	logic btn_man [gmc_pkg::NBTN];
	logic [gmc_pkg::CNT_W-1:0] btn_hold [gmc_pkg::NBTN];
	logic sec_was_act, drv_supp, manual_mv, await_rel, sec_owns;
	gmc_pkg::phase_t safety_ph;
	logic [7:0] safety_tmr;

	gate_result_t gate_results_due [$];
	gate_result_t result_want;
	int mismatches = 0;
	int results_seen = 0;
	int burst_left = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int stall_left = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void reset_gate_model();
		cfg_hold = gmc_pkg::HOLD_RST;
		cfg_settle = gmc_pkg::SETTLE_RST;
		cfg_reverse = gmc_pkg::REVERSE_RST;
		gate_st = gmc_pkg::GC_IDLE_CLOSED;
		for (int i = 0; i < gmc_pkg::NBTN; i++) begin
			btn_last[i] = 1'b0;
			btn_man[i] = 1'b0;
			btn_hold[i] = '0;
		end
		sec_was_act = 1'b0;
		drv_supp = 1'b0;
		manual_mv = 1'b0;
		await_rel = 1'b0;
		sec_owns = 1'b0;
		safety_ph = gmc_pkg::PH_IDLE;
		safety_tmr = '0;
	endfunction

	function automatic gmc_pkg::event_t release_press(int b, gmc_pkg::event_t auto_ev);
		gmc_pkg::event_t ev;
		ev = btn_man[b] ? gmc_pkg::EV_RELEASE : auto_ev;
		btn_man[b] = 1'b0;
		return ev;
	endfunction

	function automatic void apply_gate_event(gmc_pkg::event_t ev, logic sec);
		logic [gmc_pkg::GATE_W-1:0] cur;
		cur = gate_st;
		if (ev == gmc_pkg::EV_NONE) return;
		if (sec_owns && !sec) return;
		if (await_rel) begin
			if (ev == gmc_pkg::EV_OPEN_AUTO || ev == gmc_pkg::EV_CLOSE_AUTO) begin
				await_rel = 1'b0;
				manual_mv = 1'b0;
			end else begin
				if (ev == gmc_pkg::EV_RELEASE || ev == gmc_pkg::EV_STOP) await_rel = 1'b0;
				return;
			end
		end
		case (ev)
			gmc_pkg::EV_OPEN_AUTO: begin
				if (cur == gmc_pkg::GC_IDLE_CLOSED || cur == gmc_pkg::GC_STOPPED ||
						cur == gmc_pkg::GC_CLOSING) begin
					gate_st = gmc_pkg::GC_OPENING;
					manual_mv = 1'b0;
					sec_owns = sec;
				end
			end
			gmc_pkg::EV_CLOSE_AUTO: begin
				if (cur == gmc_pkg::GC_IDLE_OPEN || cur == gmc_pkg::GC_STOPPED ||
						cur == gmc_pkg::GC_OPENING) begin
					gate_st = gmc_pkg::GC_CLOSING;
					manual_mv = 1'b0;
					sec_owns = sec;
				end
			end
			gmc_pkg::EV_OPEN_MAN: begin
				if (cur != gmc_pkg::GC_IDLE_OPEN && cur != gmc_pkg::GC_REVERSING) begin
					gate_st = gmc_pkg::GC_OPENING;
					manual_mv = 1'b1;
					sec_owns = sec;
				end
			end
			gmc_pkg::EV_CLOSE_MAN: begin
				if (cur != gmc_pkg::GC_IDLE_CLOSED && cur != gmc_pkg::GC_REVERSING) begin
					gate_st = gmc_pkg::GC_CLOSING;
					manual_mv = 1'b1;
					sec_owns = sec;
				end
			end
			gmc_pkg::EV_RELEASE: begin
				if (manual_mv && (cur == gmc_pkg::GC_OPENING ||
						cur == gmc_pkg::GC_CLOSING)) begin
					gate_st = gmc_pkg::GC_STOPPED;
					manual_mv = 1'b0;
					sec_owns = 1'b0;
				end
			end
			default: begin
				if (cur == gmc_pkg::GC_OPENING || cur == gmc_pkg::GC_CLOSING)
					gate_st = gmc_pkg::GC_STOPPED;
				manual_mv = 1'b0;
				sec_owns = 1'b0;
			end
		endcase
	endfunction

	function automatic gate_result_t advance_gate(tick_t t);
		logic now [gmc_pkg::NBTN];
		logic sec_act, sec_just, sec, busy, started;
		gmc_pkg::event_t ev;
		gate_result_t r;
		now[gmc_pkg::BTN_DO] = t.d_open;
		now[gmc_pkg::BTN_DC] = t.d_close;
		now[gmc_pkg::BTN_SO] = t.s_open;
		now[gmc_pkg::BTN_SC] = t.s_close;
		sec = 1'b0;
		started = 1'b0;
		ev = gmc_pkg::EV_NONE;

		for (int i = 0; i < gmc_pkg::NBTN; i++) begin
			if (now[i] && !btn_last[i]) begin
				btn_hold[i] = '0;
				btn_man[i] = 1'b0;
			end else if (now[i] && btn_hold[i] < gmc_pkg::CNT_MAX) begin
				btn_hold[i] = btn_hold[i] + 1'b1;
			end
			if (now[i] && btn_hold[i] >= cfg_hold) btn_man[i] = 1'b1;
		end
		sec_act = now[gmc_pkg::BTN_SO] || now[gmc_pkg::BTN_SC];
		sec_just = sec_act && !sec_was_act;
		if (sec_act) drv_supp = 1'b1;

		if (sec_just) begin
			ev = gmc_pkg::EV_STOP;
			sec = 1'b1;
		end else if (!now[gmc_pkg::BTN_SO] && btn_last[gmc_pkg::BTN_SO]) begin
			ev = release_press(gmc_pkg::BTN_SO, gmc_pkg::EV_OPEN_AUTO);
			sec = 1'b1;
		end else if (!now[gmc_pkg::BTN_SC] && btn_last[gmc_pkg::BTN_SC]) begin
			ev = release_press(gmc_pkg::BTN_SC, gmc_pkg::EV_CLOSE_AUTO);
			sec = 1'b1;
		end else if (!now[gmc_pkg::BTN_DO] && btn_last[gmc_pkg::BTN_DO] && !drv_supp) begin
			ev = release_press(gmc_pkg::BTN_DO, gmc_pkg::EV_OPEN_AUTO);
		end else if (!now[gmc_pkg::BTN_DC] && btn_last[gmc_pkg::BTN_DC] && !drv_supp) begin
			ev = release_press(gmc_pkg::BTN_DC, gmc_pkg::EV_CLOSE_AUTO);
		end else if (sec_act) begin
			sec = 1'b1;
			if (now[gmc_pkg::BTN_SO] && now[gmc_pkg::BTN_SC])
				ev = gmc_pkg::EV_STOP;
			else if (now[gmc_pkg::BTN_SO] && btn_man[gmc_pkg::BTN_SO])
				ev = gmc_pkg::EV_OPEN_MAN;
			else if (now[gmc_pkg::BTN_SC] && btn_man[gmc_pkg::BTN_SC])
				ev = gmc_pkg::EV_CLOSE_MAN;
		end else if (!drv_supp) begin
			if (now[gmc_pkg::BTN_DO] && now[gmc_pkg::BTN_DC])
				ev = gmc_pkg::EV_STOP;
			else if (now[gmc_pkg::BTN_DO] && btn_man[gmc_pkg::BTN_DO])
				ev = gmc_pkg::EV_OPEN_MAN;
			else if (now[gmc_pkg::BTN_DC] && btn_man[gmc_pkg::BTN_DC])
				ev = gmc_pkg::EV_CLOSE_MAN;
		end
		if (ev == gmc_pkg::EV_NONE) sec = 1'b0;
		for (int i = 0; i < gmc_pkg::NBTN; i++) btn_last[i] = now[i];
		sec_was_act = sec_act;
		if (!sec_act && !now[gmc_pkg::BTN_DO] && !now[gmc_pkg::BTN_DC]) drv_supp = 1'b0;

		// obstacle recovery sequence
		busy = (safety_ph != gmc_pkg::PH_IDLE);
		if (safety_ph == gmc_pkg::PH_SETTLE) begin
			if (safety_tmr != 0) safety_tmr = safety_tmr - 1'b1;
			if (safety_tmr == 0) begin
				gate_st = gmc_pkg::GC_REVERSING;
				safety_ph = gmc_pkg::PH_REVERSE;
				safety_tmr = cfg_reverse;
			end
		end else if (safety_ph == gmc_pkg::PH_REVERSE) begin
			if (safety_tmr != 0) safety_tmr = safety_tmr - 1'b1;
			if (safety_tmr == 0) begin
				gate_st = gmc_pkg::GC_STOPPED;
				safety_ph = gmc_pkg::PH_IDLE;
			end
		end

		if (t.lim_open) begin
			if (gate_st == gmc_pkg::GC_OPENING) gate_st = gmc_pkg::GC_IDLE_OPEN;
			manual_mv = 1'b0;
			sec_owns = 1'b0;
		end
		if (t.lim_close) begin
			if (gate_st == gmc_pkg::GC_CLOSING) gate_st = gmc_pkg::GC_IDLE_CLOSED;
			manual_mv = 1'b0;
			sec_owns = 1'b0;
		end

		if (t.obstacle && gate_st == gmc_pkg::GC_CLOSING) begin
			gate_st = gmc_pkg::GC_STOPPED;
			safety_ph = gmc_pkg::PH_SETTLE;
			safety_tmr = cfg_settle;
			await_rel = 1'b1;
			manual_mv = 1'b0;
			sec_owns = 1'b0;
			started = 1'b1;
		end

		if (!busy && !started) apply_gate_event(ev, sec);

		r.gate = gate_st;
		r.motor_open = (gate_st == gmc_pkg::GC_OPENING) || (gate_st == gmc_pkg::GC_REVERSING);
		r.motor_close = (gate_st == gmc_pkg::GC_CLOSING);
		r.led_red = (gate_st == gmc_pkg::GC_CLOSING) || (gate_st == gmc_pkg::GC_STOPPED) ||
			(gate_st == gmc_pkg::GC_REVERSING);
		r.led_green = (gate_st == gmc_pkg::GC_IDLE_OPEN) || (gate_st == gmc_pkg::GC_OPENING) ||
			(gate_st == gmc_pkg::GC_STOPPED);
		r.led_blue = (gate_st == gmc_pkg::GC_IDLE_CLOSED) || (gate_st == gmc_pkg::GC_IDLE_OPEN) ||
			(gate_st == gmc_pkg::GC_REVERSING);
		r.ev = ev;
		r.from_sec = sec;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
	endtask

	// receiver stall pattern
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 2));
			stall_left = $urandom_range(8, 60);
		end else begin
			stall_left = stall_left - 1;
		end
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			default:     out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// a transaction on the result side is taken at the next rising edge
	always @(negedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (gate_results_due.size() == 0) begin
				report_mismatch("unexpected transaction", 8'd1, 8'd0);
			end else begin
				result_want = gate_results_due.pop_front();
				if (gate_state !== result_want.gate)
					report_mismatch("gate_state", 8'(gate_state), 8'(result_want.gate));
				if (motor_open !== result_want.motor_open)
					report_mismatch("motor_open", 8'(motor_open), 8'(result_want.motor_open));
				if (motor_close !== result_want.motor_close)
					report_mismatch("motor_close", 8'(motor_close),
						8'(result_want.motor_close));
				if (led_red !== result_want.led_red)
					report_mismatch("led_red", 8'(led_red), 8'(result_want.led_red));
				if (led_green !== result_want.led_green)
					report_mismatch("led_green", 8'(led_green), 8'(result_want.led_green));
				if (led_blue !== result_want.led_blue)
					report_mismatch("led_blue", 8'(led_blue), 8'(result_want.led_blue));
				if (issued_event !== result_want.ev)
					report_mismatch("issued_event", 8'(issued_event), 8'(result_want.ev));
				if (event_from_security !== result_want.from_sec)
					report_mismatch("event_from_security", 8'(event_from_security),
						8'(result_want.from_sec));
			end
			results_seen++;
		end
	end

	task automatic send_tick(tick_t t);
		int gap;
		logic taken;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(0, 5);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
		tick_drv <= t;
		in_valid <= 1'b1;
		do begin
			@(negedge clk);
			taken = (in_stall === 1'b0);
			@(posedge clk);
		end while (!taken);
		gate_results_due.push_back(advance_gate(t));
	endtask

	task automatic quiesce();
		in_valid <= 1'b0;
		while (gate_results_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [gmc_pkg::CFG_IDX_W-1:0] idx,
			logic [gmc_pkg::REG_W-1:0] val);
		logic taken;
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do begin
			@(negedge clk);
			taken = (cfg_ready === 1'b1);
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
		case (idx)
			gmc_pkg::CFG_HOLD:    cfg_hold = val;
			gmc_pkg::CFG_SETTLE:  cfg_settle = val;
			gmc_pkg::CFG_REVERSE: cfg_reverse = val;
			default:              ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(logic [gmc_pkg::REG_W-1:0] hold,
			logic [gmc_pkg::REG_W-1:0] settle, logic [gmc_pkg::REG_W-1:0] reverse);
		quiesce();
		write_reg(gmc_pkg::CFG_HOLD, hold);
		write_reg(gmc_pkg::CFG_SETTLE, settle);
		write_reg(gmc_pkg::CFG_REVERSE, reverse);
	endtask

	// btns is {driver open, driver close, security open, security close}
	function automatic tick_t sensor_tick(logic [3:0] btns);
		tick_t t;
		{t.d_open, t.d_close, t.s_open, t.s_close} = btns;
		t.lim_open = ($urandom_range(0, 9) == 0);
		t.lim_close = ($urandom_range(0, 9) == 0);
		t.obstacle = ($urandom_range(0, 5) == 0);
		return t;
	endfunction

	// press/hold/release gestures with random sensors, some raw noise
	task automatic run_gestures(int count);
		int sent, dur, rel;
		logic [3:0] btns;
		logic [6:0] noise;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 99) < 15) begin
				noise = 7'($urandom);
				send_tick(tick_t'(noise));
				sent++;
			end else begin
				case ($urandom_range(0, 7))
					0: btns = 4'b1000;
					1: btns = 4'b0100;
					2: btns = 4'b0010;
					3: btns = 4'b0001;
					4: btns = 4'b1100;
					5: btns = 4'b0011;
					6: btns = 4'b1010;
					default: btns = 4'b0101;
				endcase
				if ($urandom_range(0, 1) == 0) begin
					dur = $urandom_range(1, 2);
				end else begin
					dur = cfg_hold + $urandom_range(0, 3);
					if (dur > 30) dur = $urandom_range(20, 30);
				end
				rel = $urandom_range(1, 3);
				for (int k = 0; k < dur; k++) send_tick(sensor_tick(btns));
				for (int k = 0; k < rel; k++) send_tick(sensor_tick(4'b0000));
				sent += dur + rel;
			end
		end
	endtask

	task automatic test_directed();
		// bits: d_open d_close s_open s_close lim_open lim_close obstacle
		logic [6:0] seq [26];
		seq = '{7'b0000000, 7'b1111111, 7'b0000000, 7'b1000000, 7'b0000000,
			7'b0000100, 7'b0000001, 7'b0100000, 7'b0000000, 7'b0000011,
			7'b1000000, 7'b0000000, 7'b0100000, 7'b0000000, 7'b0000001,
			7'b1000000, 7'b1000000, 7'b1000000, 7'b0000000, 7'b1100000,
			7'b0011000, 7'b0000000, 7'b0010000, 7'b0010000, 7'b0010000,
			7'b0000000};
		for (int i = 0; i < 3; i++) send_tick(tick_t'(seq[i]));
		// zero settle and reverse times take one tick each
		set_config(8'd2, 8'd0, 8'd0);
		for (int i = 3; i < 26; i++) send_tick(tick_t'(seq[i]));
	endtask

	task automatic test_hold_saturation();
		set_config(8'd255, 8'd255, 8'd255);
		send_tick(sensor_tick(4'b0001));
		send_tick(sensor_tick(4'b0000));
		// driver open held past the counter ceiling
		for (int i = 0; i < 262; i++) send_tick(sensor_tick(4'b1000));
		send_tick(sensor_tick(4'b0000));
		send_tick(sensor_tick(4'b0000));
	endtask

	task automatic test_instant_manual();
		set_config(8'd0, 8'd1, 8'd0);
		run_gestures(60);
		quiesce();
		write_reg(CFG_UNUSED, 8'($urandom));
		run_gestures(20);
	endtask

	task automatic test_random();
		set_config(gmc_pkg::HOLD_RST, gmc_pkg::SETTLE_RST, gmc_pkg::REVERSE_RST);
		run_gestures(120);
		set_config(8'd1, 8'd0, 8'd1);
		run_gestures(60);
		quiesce();
		run_gestures(60);
		set_config(8'd4, 8'd2, 8'd6);
		run_gestures(120);
		set_config(8'($urandom_range(1, 12)), 8'($urandom_range(0, 8)),
			8'($urandom_range(1, 16)));
		run_gestures(140);
	endtask

	initial begin
		reset_gate_model();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_hold_saturation();
		test_instant_manual();
		test_random();
		quiesce();
		if (mismatches == 0 && gate_results_due.size() == 0) begin
			$display("tb_gate_motion_controller_core OK");
		end else begin
			$display("tb_gate_motion_controller_core NOT OK");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_gate_motion_controller_core NOT OK");
		$finish;
	end

endmodule

`default_nettype wire

/* gate_motion_controller_core.f */
+incdir+sv
sv/gmc_pkg.sv
sv/gmc_buttons.sv
sv/gmc_fsm.sv
sv/gate_motion_controller_core.sv
tb/sv/tb_gate_motion_controller_core.sv
